>>> rtl/core/raster_rle_byte_decoder_unit_defines.svh
// Assertion macros for the raster RLE byte decoder.
// RRLE_ASSERT_IMP checks pre |-> post, RRLE_ASSERT_NXT checks pre |=> post.
`ifndef RASTER_RLE_BYTE_DECODER_UNIT_DEFINES_SVH
`define RASTER_RLE_BYTE_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define RRLE_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("rrle assertion failed");
`define RRLE_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("rrle assertion failed");
`else
`define RRLE_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define RRLE_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

>>> rtl/core/rrle_pkg.sv
package rrle_pkg;

	// field widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 9;
	localparam int LW_W   = 14;
	localparam int TL_W   = 28;
	localparam int LP_W   = 15;

	// escape byte and narrowest line
	localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'd128;
	localparam logic [LW_W-1:0]   MIN_WIDTH = 14'd8;

	// configuration register indexes
	localparam logic REG_LINE_WIDTH   = 1'b0;
	localparam logic REG_TOTAL_LENGTH = 1'b1;

	// run load sources
	localparam logic [1:0] SRC_LIT  = 2'd0; // one copy of the input byte
	localparam logic [1:0] SRC_ESC1 = 2'd1; // one 128
	localparam logic [1:0] SRC_ESC2 = 2'd2; // two 128s
	localparam logic [1:0] SRC_CNT  = 2'd3; // count + 1 copies of the input byte

	typedef struct packed {
		logic       clear_image;
		logic       save_count;
		logic       load_run;
		logic [1:0] load_src;
		logic       step_run;
		logic       emit_bad;
	} ctrl_cmd_t;

	typedef struct packed {
		logic byte_is_esc;
		logic byte_is_zero;
		logic byte_is_one;
		logic run_final;
		logic run_done;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/core/rrle_ctrl.sv
module rrle_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   start_image,
	input  rrle_pkg::dp_status_t   stat,
	output rrle_pkg::ctrl_cmd_t    cmd
);

	// controller states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	// decode phases
	localparam logic [1:0] PH_LITERAL = 2'd0;
	localparam logic [1:0] PH_ESCAPE  = 2'd1;
	localparam logic [1:0] PH_ONE     = 2'd2;
	localparam logic [1:0] PH_COUNT   = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       halted_q, halted_d;
	logic       accept;
	logic [1:0] eff_phase;
	logic       eff_halted;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// start_image clears decode state ahead of this byte
	assign eff_phase  = start_image ? PH_LITERAL : phase_q;
	assign eff_halted = start_image ? 1'b0 : halted_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		halted_d = halted_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.clear_image = start_image;
					phase_d         = eff_phase;
					halted_d        = eff_halted;
					if (!eff_halted) begin
						unique case (eff_phase)
							PH_LITERAL: begin
								if (stat.byte_is_esc) begin
									phase_d = PH_ESCAPE;
								end else begin
									cmd.load_run = 1'b1;
									cmd.load_src = rrle_pkg::SRC_LIT;
									state_d      = ST_RUN;
								end
							end
							PH_ESCAPE: begin
								if (stat.byte_is_zero) begin
									phase_d      = PH_LITERAL;
									cmd.load_run = 1'b1;
									cmd.load_src = rrle_pkg::SRC_ESC1;
									state_d      = ST_RUN;
								end else if (stat.byte_is_one) begin
									phase_d = PH_ONE;
								end else begin
									cmd.save_count = 1'b1;
									phase_d        = PH_COUNT;
								end
							end
							PH_ONE: begin
								phase_d = PH_LITERAL;
								if (stat.byte_is_esc) begin
									cmd.load_run = 1'b1;
									cmd.load_src = rrle_pkg::SRC_ESC2;
									state_d      = ST_RUN;
								end else begin
									state_d = ST_BAD;
								end
							end
							PH_COUNT: begin
								phase_d      = PH_LITERAL;
								cmd.load_run = 1'b1;
								cmd.load_src = rrle_pkg::SRC_CNT;
								state_d      = ST_RUN;
							end
							default: begin
								phase_d = PH_LITERAL;
							end
						endcase
					end
				end
			end
			ST_RUN: begin
				if (stat.out_free) begin
					cmd.step_run = 1'b1;
					if (stat.run_done) begin
						halted_d = 1'b1;
					end
					if (stat.run_final) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_BAD: begin
				if (stat.out_free) begin
					cmd.emit_bad = 1'b1;
					halted_d     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_LITERAL;
			halted_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			halted_q <= halted_d;
		end
	end

endmodule

>>> rtl/core/rrle_dpath.sv
module rrle_dpath #(
	parameter int COUNT_BITS = 28
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [rrle_pkg::BYTE_W-1:0]        in_byte,
	input  logic [rrle_pkg::LW_W-1:0]          line_width,
	input  logic [rrle_pkg::TL_W-1:0]          total_length,
	input  rrle_pkg::ctrl_cmd_t                cmd,
	output rrle_pkg::dp_status_t               stat,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [rrle_pkg::BYTE_W-1:0]        seg_value,
	output logic [rrle_pkg::LEN_W-1:0]         seg_length,
	output logic                               image_done,
	output logic                               corrupt,
	output logic                               last
);

	localparam int PcW  = COUNT_BITS + 1;
	localparam int LimW = ((COUNT_BITS > rrle_pkg::TL_W) ? COUNT_BITS : rrle_pkg::TL_W) + 1;
	localparam logic [LimW-1:0] CntMax = LimW'((64'd1 << COUNT_BITS) - 64'd1);
	localparam int LpW  = rrle_pkg::LP_W;
	localparam int LenW = rrle_pkg::LEN_W;

	// run and image registers
	logic [rrle_pkg::BYTE_W-1:0] val_q;
	logic [LenW-1:0]             rem_q;
	logic [LenW-1:0]             seg_q;
	logic [rrle_pkg::BYTE_W-1:0] cnt_q;
	logic [LpW-1:0]              lp_q;
	logic [PcW-1:0]              pc_q;

	// output register
	logic                        out_valid_q;
	logic [rrle_pkg::BYTE_W-1:0] seg_value_q;
	logic [LenW-1:0]             seg_length_q;
	logic                        image_done_q;
	logic                        corrupt_q;
	logic                        last_q;

	logic [rrle_pkg::LW_W-1:0] w_eff;
	logic [LpW-1:0]            w15;
	logic                      odd;
	logic [LimW-1:0]           tl_ext;
	logic [LimW-1:0]           lim_wide;
	logic [PcW-1:0]            lim;
	logic [PcW:0]              gap;
	logic                      gap_le0;
	logic                      gap_big;
	logic [LenW-1:0]           budget;
	logic                      lp_lt;
	logic [LpW-1:0]            room15;
	logic [LenW-1:0]           line_room;
	logic                      pad;
	logic [LenW-1:0]           k_ab;
	logic [LenW-1:0]           k;
	logic [LenW-1:0]           cons;
	logic [LenW-1:0]           rem_n;
	logic                      done_n;
	logic                      final_n;
	logic [LenW-1:0]           seg_sum;
	logic                      emit;
	logic [LenW-1:0]           emit_len;
	logic [LpW:0]              lp_sum;
	logic [LpW-1:0]            lp_n;
	logic                      out_free;
	logic                      step_emit;

	// effective line width and limit
	assign w_eff    = (line_width < rrle_pkg::MIN_WIDTH) ? rrle_pkg::MIN_WIDTH : line_width;
	assign w15      = LpW'(w_eff);
	assign odd      = w_eff[0];
	assign tl_ext   = LimW'(total_length);
	assign lim_wide = (total_length == '0) ? LimW'(1) :
	                  ((tl_ext > CntMax) ? CntMax : tl_ext);
	assign lim      = lim_wide[PcW-1:0];

	// bytes left before the limit, clipped to one run
	assign gap     = {1'b0, lim} - {1'b0, pc_q};
	assign gap_le0 = gap[PcW] || (gap == '0);
	assign gap_big = !gap[PcW] && (gap > (PcW+1)'(256));
	assign budget  = gap_le0 ? LenW'(1) : (gap_big ? LenW'(256) : gap[LenW-1:0]);

	// bytes left before the line end or pad
	assign lp_lt     = lp_q < w15;
	assign room15    = w15 - lp_q;
	assign line_room = lp_lt ? ((room15 > LpW'(256)) ? LenW'(256) : room15[LenW-1:0]) :
	                   (odd ? LenW'(256) : LenW'(1));
	assign pad       = odd && (lp_q == w15);

	// chunk length: smallest of run, limit and line room
	assign k_ab = (rem_q < budget) ? rem_q : budget;
	assign k    = (k_ab < line_room) ? k_ab : line_room;
	assign cons = pad ? LenW'(1) : k;

	assign rem_n   = rem_q - cons;
	assign done_n  = (cons == budget) && !gap_big;
	assign final_n = (rem_n == '0) || done_n;
	assign seg_sum = seg_q + k;

	// a pad flushes an open segment, or an empty one when it reaches the limit; any other final chunk flushes
	assign emit     = pad ? ((seg_q != '0) || (final_n && done_n)) : final_n;
	assign emit_len = pad ? seg_q : seg_sum;

	// line position update
	assign lp_sum = {1'b0, lp_q} + (LpW+1)'(k);
	always_comb begin
		if (pad) begin
			lp_n = '0;
		end else if (lp_lt) begin
			lp_n = (!odd && (lp_sum[LpW-1:0] == w15)) ? '0 : lp_sum[LpW-1:0];
		end else if (odd) begin
			lp_n = lp_sum[LpW] ? '1 : lp_sum[LpW-1:0];
		end else begin
			lp_n = '0;
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign step_emit = cmd.step_run && emit;

	// status to the controller
	assign stat.byte_is_esc  = (in_byte == rrle_pkg::ESC_BYTE);
	assign stat.byte_is_zero = (in_byte == 8'd0);
	assign stat.byte_is_one  = (in_byte == 8'd1);
	assign stat.run_final    = final_n;
	assign stat.run_done     = done_n;
	assign stat.out_free     = out_free;

	// run registers
	always_ff @(posedge clk) begin
		if (cmd.load_run) begin
			seg_q <= '0;
			case (cmd.load_src)
				rrle_pkg::SRC_LIT: begin
					val_q <= in_byte;
					rem_q <= LenW'(1);
				end
				rrle_pkg::SRC_ESC1: begin
					val_q <= rrle_pkg::ESC_BYTE;
					rem_q <= LenW'(1);
				end
				rrle_pkg::SRC_ESC2: begin
					val_q <= rrle_pkg::ESC_BYTE;
					rem_q <= LenW'(2);
				end
				default: begin
					val_q <= in_byte;
					rem_q <= LenW'(cnt_q) + LenW'(1);
				end
			endcase
		end else if (cmd.step_run) begin
			rem_q <= rem_n;
			seg_q <= pad ? '0 : seg_sum;
		end
	end

	// image registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lp_q  <= '0;
			pc_q  <= '0;
		end else begin
			if (cmd.clear_image) begin
				cnt_q <= '0;
				lp_q  <= '0;
				pc_q  <= '0;
			end else if (cmd.step_run) begin
				lp_q <= lp_n;
				pc_q <= pc_q + PcW'(cons);
			end
			if (cmd.save_count) begin
				cnt_q <= in_byte;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_emit || cmd.emit_bad) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (step_emit) begin
			seg_value_q  <= val_q;
			seg_length_q <= emit_len;
			image_done_q <= final_n && done_n;
			corrupt_q    <= 1'b0;
			last_q       <= final_n;
		end else if (cmd.emit_bad) begin
			seg_value_q  <= '0;
			seg_length_q <= '0;
			image_done_q <= 1'b0;
			corrupt_q    <= 1'b1;
			last_q       <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign seg_value  = seg_value_q;
	assign seg_length = seg_length_q;
	assign image_done = image_done_q;
	assign corrupt    = corrupt_q;
	assign last       = last_q;

endmodule

>>> rtl/core/raster_rle_byte_decoder_unit.sv
// Rasterfile run-length decoder: takes one encoded byte per transaction and
// returns the decoded data as segments of equal bytes, each carrying value,
// length, image_done, corrupt and last (last marks the final segment a byte
// causes). Escape and count bytes are taken without holding the input off
// and return nothing. A byte that completes a run then holds the input off
// while the segment unit walks the run, one line piece or pad byte at a
// time, and while the output side stalls; a broken escape-one sequence
// holds it off until its corrupt report is in the output register. The
// single segment unit works through one line piece at a time. After
// image_done or corrupt the decoder ignores bytes until one arrives with
// start_image set. The user must write line_width and total_length through
// the cfg port only while no transaction is in flight; the block does not
// enforce this. There is no reset sweep.
`include "raster_rle_byte_decoder_unit_defines.svh"

module raster_rle_byte_decoder_unit #(
	parameter int COUNT_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [rrle_pkg::TL_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rrle_pkg::BYTE_W-1:0]   in_byte,
	input  logic                          start_image,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rrle_pkg::BYTE_W-1:0]   seg_value,
	output logic [rrle_pkg::LEN_W-1:0]    seg_length,
	output logic                          image_done,
	output logic                          corrupt,
	output logic                          last
);

	logic [rrle_pkg::LW_W-1:0] line_width_q;
	logic [rrle_pkg::TL_W-1:0] total_length_q;
	rrle_pkg::ctrl_cmd_t       cmd;
	rrle_pkg::dp_status_t      stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= rrle_pkg::LW_W'(8);
			total_length_q <= rrle_pkg::TL_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rrle_pkg::REG_LINE_WIDTH: begin
					line_width_q <= cfg_data[rrle_pkg::LW_W-1:0];
				end
				rrle_pkg::REG_TOTAL_LENGTH: begin
					total_length_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	rrle_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_image (start_image),
		.stat        (stat),
		.cmd         (cmd)
	);

	rrle_dpath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.line_width   (line_width_q),
		.total_length (total_length_q),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.seg_value    (seg_value),
		.seg_length   (seg_length),
		.image_done   (image_done),
		.corrupt      (corrupt),
		.last         (last)
	);

	// a corrupt report is a lone empty segment
	`RRLE_ASSERT_IMP(a_corrupt_shape, clk, arst_n, out_valid && corrupt, last && !image_done && (seg_length == '0) && (seg_value == '0))
	// the image ends on the final segment of its byte
	`RRLE_ASSERT_IMP(a_done_is_last, clk, arst_n, out_valid && image_done, last)
	// only the end of an image or a corrupt report may carry an empty segment
	`RRLE_ASSERT_IMP(a_len_nonzero, clk, arst_n, out_valid && !corrupt && !image_done, seg_length != '0)
	// a run in flight holds the input off
	`RRLE_ASSERT_NXT(a_hold_off, clk, arst_n, out_valid && !out_ready && !last, !in_ready)

endmodule

>>> tb/sv/tb_raster_rle_byte_decoder_unit.sv
`timescale 1ns / 100ps

module tb_raster_rle_byte_decoder_unit;

	localparam int COUNT_BITS = 28;
	localparam int unsigned COUNT_MAX = (32'd1 << COUNT_BITS) - 1;
	localparam logic [rrle_pkg::LW_W-1:0] RESET_LINE_WIDTH = 14'd8;
	localparam logic [rrle_pkg::TL_W-1:0] RESET_TOTAL_LENGTH = 28'd1;
	localparam logic [rrle_pkg::TL_W-1:0] TOTAL_LENGTH_MAX = 28'hFFF_FFFF;
	localparam logic [rrle_pkg::LW_W-1:0] LINE_WIDTH_MAX = 14'h3FFF;
	// count bytes with a meaning of their own after an escape
	localparam logic [rrle_pkg::BYTE_W-1:0] ESC_SINGLE = 8'd0;
	localparam logic [rrle_pkg::BYTE_W-1:0] ESC_PAIR = 8'd1;
	localparam int RANDOM_ITEMS = 480;
	localparam int DRAIN_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [1:0] {DEC_LITERAL, DEC_ESCAPE, DEC_ONE, DEC_COUNT} dec_phase_t;
	typedef enum logic [1:0] {PIN_MODEL, PIN_NONE, PIN_ONE} pin_mode_t;
	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [rrle_pkg::BYTE_W-1:0] seg_value;
		logic [rrle_pkg::LEN_W-1:0]  seg_length;
		logic                        image_done;
		logic                        corrupt;
		logic                        last_seg;
	} segment_t;

	typedef struct {
		row_kind_t                   kind;
		logic [rrle_pkg::BYTE_W-1:0] data;
		logic                        start;
		pin_mode_t                   pin;
		segment_t                    seg;
		logic [rrle_pkg::LW_W-1:0]   lw;
		logic [rrle_pkg::TL_W-1:0]   tl;
	} stim_row_t;

	// DUT ports
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic                        cfg_index = rrle_pkg::REG_LINE_WIDTH;
	logic [rrle_pkg::TL_W-1:0]   cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [rrle_pkg::BYTE_W-1:0] in_byte = '0;
	logic                        start_image = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [rrle_pkg::BYTE_W-1:0] seg_value;
	logic [rrle_pkg::LEN_W-1:0]  seg_length;
	logic                        image_done;
	logic                        corrupt;
	logic                        last;

	// expectation pinned to the byte on the input channel (directed rows)
	pin_mode_t pin_mode = PIN_MODEL;
	segment_t  pin_seg = '0;

	// decoder state mirror
	logic [rrle_pkg::LW_W-1:0]   m_line_width;
	logic [rrle_pkg::TL_W-1:0]   m_total_length;
	dec_phase_t                  m_phase;
	logic [rrle_pkg::BYTE_W-1:0] m_run_count;
	int unsigned                 m_line_pos;
	logic [COUNT_BITS-1:0]       m_produced;
	logic                        m_halted;

	segment_t  step_segs[$];    // segments caused by the current byte
	segment_t  pending_segs[$]; // segments still owed by the DUT
	stim_row_t stim_table[$];

	int err_count = 0;
	int sent_items = 0;
	int random_target = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	raster_rle_byte_decoder_unit #(
		.COUNT_BITS(COUNT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.start_image(start_image),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.seg_value(seg_value),
		.seg_length(seg_length),
		.image_done(image_done),
		.corrupt(corrupt),
		.last(last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic segment_t one_seg(logic [rrle_pkg::BYTE_W-1:0] v,
			logic [rrle_pkg::LEN_W-1:0] len, logic done, logic bad);
		return '{seg_value: v, seg_length: len, image_done: done, corrupt: bad,
			last_seg: 1'b1};
	endfunction

	function automatic stim_row_t byte_row(logic [rrle_pkg::BYTE_W-1:0] d, logic s,
			pin_mode_t pm = PIN_MODEL, segment_t sg = '0);
		return '{kind: ROW_BYTE, data: d, start: s, pin: pm, seg: sg, lw: '0, tl: '0};
	endfunction

	function automatic stim_row_t cfg_row(logic [rrle_pkg::LW_W-1:0] w,
			logic [rrle_pkg::TL_W-1:0] l);
		return '{kind: ROW_CFG, data: '0, start: 1'b0, pin: PIN_MODEL, seg: '0, lw: w, tl: l};
	endfunction

	function automatic void clear_image();
		m_phase = DEC_LITERAL;
		m_run_count = '0;
		m_line_pos = '0;
		m_produced = '0;
		m_halted = 1'b0;
	endfunction

	function automatic void push_seg(logic [rrle_pkg::BYTE_W-1:0] v,
			logic [rrle_pkg::LEN_W-1:0] len);
		step_segs.push_back('{seg_value: v, seg_length: len, image_done: 1'b0,
			corrupt: 1'b0, last_seg: 1'b0});
	endfunction

	// Produce n copies of v: pad bytes on odd widths split the run, the limit clips it
	function automatic void expand_run(logic [rrle_pkg::BYTE_W-1:0] v, int n);
		int unsigned w;
		int unsigned lim;
		int unsigned seg_len;
		bit odd;
		bit done;
		segment_t tail;
		seg_len = 0;
		done = 1'b0;
		w = (m_line_width < rrle_pkg::MIN_WIDTH) ? rrle_pkg::MIN_WIDTH : m_line_width;
		odd = w[0];
		lim = (m_total_length == 0) ? 1 : m_total_length;
		if (lim > COUNT_MAX) lim = COUNT_MAX;
		for (int i = 0; i < n && !done; i++) begin
			m_produced++;
			if (odd && m_line_pos == w) begin
				// pad byte: counted, not output
				m_line_pos = '0;
				if (seg_len > 0) begin
					push_seg(v, seg_len[rrle_pkg::LEN_W-1:0]);
					seg_len = 0;
				end
			end else begin
				seg_len++;
				m_line_pos++;
				if (!odd && m_line_pos >= w) m_line_pos = '0;
			end
			if (m_produced >= lim) done = 1'b1;
		end
		if (seg_len > 0) push_seg(v, seg_len[rrle_pkg::LEN_W-1:0]);
		if (done) begin
			m_halted = 1'b1;
			if (step_segs.size() == 0) push_seg(v, '0);
			tail = step_segs.pop_back();
			tail.image_done = 1'b1;
			step_segs.push_back(tail);
		end
		if (step_segs.size() > 0) begin
			tail = step_segs.pop_back();
			tail.last_seg = 1'b1;
			step_segs.push_back(tail);
		end
	endfunction

	// Decode one byte into step_segs; returns 0 when the byte is ignored
	function automatic bit decode_byte(logic [rrle_pkg::BYTE_W-1:0] b, logic s);
		step_segs.delete();
		if (s) clear_image();
		if (m_halted) return 1'b0;
		case (m_phase)
			DEC_LITERAL: begin
				if (b == rrle_pkg::ESC_BYTE) m_phase = DEC_ESCAPE;
				else expand_run(b, 1);
			end
			DEC_ESCAPE: begin
				if (b == ESC_SINGLE) begin
					m_phase = DEC_LITERAL;
					expand_run(rrle_pkg::ESC_BYTE, 1);
				end else if (b == ESC_PAIR) begin
					m_phase = DEC_ONE;
				end else begin
					m_run_count = b;
					m_phase = DEC_COUNT;
				end
			end
			DEC_ONE: begin
				m_phase = DEC_LITERAL;
				if (b != rrle_pkg::ESC_BYTE) begin
					// broken escape-one sequence
					m_halted = 1'b1;
					step_segs.push_back(one_seg('0, '0, 1'b0, 1'b1));
				end else begin
					expand_run(rrle_pkg::ESC_BYTE, 2);
				end
			end
			default: begin
				m_phase = DEC_LITERAL;
				expand_run(b, int'(m_run_count) + 1);
			end
		endcase
		return 1'b1;
	endfunction

	function automatic void check_segment();
		segment_t want;
		if (pending_segs.size() == 0) begin
			$error("unexpected segment: seg_value %0d seg_length %0d", seg_value, seg_length);
			err_count++;
			return;
		end
		want = pending_segs.pop_front();
		if (seg_value !== want.seg_value) begin
			$error("seg_value: expected %0d, actual %0d", want.seg_value, seg_value);
			err_count++;
		end
		if (seg_length !== want.seg_length) begin
			$error("seg_length: expected %0d, actual %0d", want.seg_length, seg_length);
			err_count++;
		end
		if (image_done !== want.image_done) begin
			$error("image_done: expected %0d, actual %0d", want.image_done, image_done);
			err_count++;
		end
		if (corrupt !== want.corrupt) begin
			$error("corrupt: expected %0d, actual %0d", want.corrupt, corrupt);
			err_count++;
		end
		if (last !== want.last_seg) begin
			$error("last: expected %0d, actual %0d", want.last_seg, last);
			err_count++;
		end
	endfunction

	// Monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				void'(decode_byte(in_byte, start_image));
				case (pin_mode)
					PIN_ONE: pending_segs.push_back(pin_seg);
					PIN_NONE: ;
					default: foreach (step_segs[i]) pending_segs.push_back(step_segs[i]);
				endcase
			end
			if (out_valid && out_ready) check_segment();
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	// Receiver: spans of always-ready, random ready, and long stalls
	initial begin
		int mode;
		int span;
		int hold;
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(64, 256);
			while (span > 0) begin
				case (mode)
					0: begin
						out_ready <= 1'b1;
						hold = 1;
					end
					1: begin
						out_ready <= 1'($urandom_range(0, 1));
						hold = 1;
					end
					default: begin
						out_ready <= ~out_ready;
						hold = out_ready ? $urandom_range(1, 20) : $urandom_range(1, 6);
					end
				endcase
				repeat (hold) @(posedge clk);
				span -= hold;
			end
		end
	end

	// One input transaction; the sender may idle between bursts
	task automatic send_byte(logic [rrle_pkg::BYTE_W-1:0] b, logic s,
			pin_mode_t pm = PIN_MODEL, segment_t ps = '0);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte <= b;
		start_image <= s;
		pin_mode <= pm;
		pin_seg <= ps;
		do @(posedge clk); while (!in_ready);
		sent_items++;
	endtask

	// Drop valid, wait for every owed segment, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_segs.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [rrle_pkg::LW_W-1:0] lw, logic [rrle_pkg::TL_W-1:0] tl);
		cfg_we <= 1'b1;
		cfg_index <= rrle_pkg::REG_LINE_WIDTH;
		cfg_data <= {{(rrle_pkg::TL_W-rrle_pkg::LW_W){1'b0}}, lw};
		@(posedge clk);
		cfg_index <= rrle_pkg::REG_TOTAL_LENGTH;
		cfg_data <= tl;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_line_width = lw;
		m_total_length = tl;
	endtask

	// One encoded token: mostly well-formed, some corrupt sequences and noise
	task automatic send_token(logic s);
		int pick;
		logic [rrle_pkg::BYTE_W-1:0] v;
		logic [rrle_pkg::BYTE_W-1:0] n;
		pick = $urandom_range(0, 99);
		v = 8'($urandom());
		if (pick < 45) begin
			if (v == rrle_pkg::ESC_BYTE) v = v ^ 8'h01;
			send_byte(v, s);
		end else if (pick < 53) begin
			send_byte(rrle_pkg::ESC_BYTE, s);
			send_byte(ESC_SINGLE, 1'b0);
		end else if (pick < 61) begin
			send_byte(rrle_pkg::ESC_BYTE, s);
			send_byte(ESC_PAIR, 1'b0);
			send_byte(rrle_pkg::ESC_BYTE, 1'b0);
		end else if (pick < 88) begin
			n = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255))
				: 8'($urandom_range(2, 20));
			send_byte(rrle_pkg::ESC_BYTE, s);
			send_byte(n, 1'b0);
			send_byte(v, 1'b0);
		end else if (pick < 92) begin
			if (v == rrle_pkg::ESC_BYTE) v = 8'h00;
			send_byte(rrle_pkg::ESC_BYTE, s);
			send_byte(ESC_PAIR, 1'b0);
			send_byte(v, 1'b0);
		end else begin
			send_byte(8'($urandom()), 1'($urandom_range(0, 7) == 0));
		end
	endtask

	// New register setting, then a few images (the first may continue the old one)
	task automatic random_phase();
		logic [rrle_pkg::LW_W-1:0] lw;
		logic [rrle_pkg::TL_W-1:0] tl;
		int images;
		int tokens;
		logic first_start;
		case ($urandom_range(0, 9))
			0, 1, 2: lw = 14'(9 + 2 * $urandom_range(0, 3));
			3, 4: lw = 14'(2 * $urandom_range(4, 12));
			5: lw = 14'($urandom_range(0, 7));
			6: lw = LINE_WIDTH_MAX;
			7: lw = 14'($urandom_range(8, 60));
			8: lw = 14'($urandom());
			default: lw = 14'd9;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2: tl = 28'($urandom_range(1, 60));
			3, 4, 5, 6: tl = 28'($urandom_range(61, 1500));
			7: tl = TOTAL_LENGTH_MAX;
			8: tl = '0;
			default: tl = 28'($urandom());
		endcase
		wait_idle();
		set_config(lw, tl);
		images = $urandom_range(1, 4);
		for (int k = 0; k < images && sent_items < random_target; k++) begin
			first_start = (k > 0) || ($urandom_range(0, 3) != 0);
			tokens = $urandom_range(3, 40);
			for (int t = 0; t < tokens && sent_items < random_target; t++)
				send_token((t == 0) ? first_start : 1'b0);
		end
	endtask

	initial begin
		m_line_width = RESET_LINE_WIDTH;
		m_total_length = RESET_TOTAL_LENGTH;
		clear_image();

		// reset register values: one byte ends the image, the next is ignored
		stim_table.push_back(byte_row(8'h00, 1'b1, PIN_ONE, one_seg(8'h00, 9'd1, 1'b1, 1'b0)));
		stim_table.push_back(byte_row(8'hFF, 1'b0, PIN_NONE));
		// odd width, largest limit: each escape form
		stim_table.push_back(cfg_row(14'd9, TOTAL_LENGTH_MAX));
		stim_table.push_back(byte_row(8'hFF, 1'b1, PIN_ONE, one_seg(8'hFF, 9'd1, 1'b0, 1'b0)));
		stim_table.push_back(byte_row(rrle_pkg::ESC_BYTE, 1'b0, PIN_NONE));
		stim_table.push_back(byte_row(ESC_SINGLE, 1'b0, PIN_ONE,
			one_seg(rrle_pkg::ESC_BYTE, 9'd1, 1'b0, 1'b0)));
		stim_table.push_back(byte_row(rrle_pkg::ESC_BYTE, 1'b0, PIN_NONE));
		stim_table.push_back(byte_row(ESC_PAIR, 1'b0, PIN_NONE));
		stim_table.push_back(byte_row(rrle_pkg::ESC_BYTE, 1'b0, PIN_ONE,
			one_seg(rrle_pkg::ESC_BYTE, 9'd2, 1'b0, 1'b0)));
		// longest run, split by pad bytes
		stim_table.push_back(byte_row(rrle_pkg::ESC_BYTE, 1'b0, PIN_NONE));
		stim_table.push_back(byte_row(8'hFF, 1'b0, PIN_NONE));
		stim_table.push_back(byte_row(8'hA5, 1'b0));
		// escape-one without the escape byte
		stim_table.push_back(byte_row(rrle_pkg::ESC_BYTE, 1'b0, PIN_NONE));
		stim_table.push_back(byte_row(ESC_PAIR, 1'b0, PIN_NONE));
		stim_table.push_back(byte_row(8'h7F, 1'b0, PIN_ONE, one_seg('0, '0, 1'b0, 1'b1)));
		// start_image clears a pending escape
		stim_table.push_back(byte_row(rrle_pkg::ESC_BYTE, 1'b1, PIN_NONE));
		stim_table.push_back(byte_row(8'h10, 1'b1, PIN_ONE, one_seg(8'h10, 9'd1, 1'b0, 1'b0)));
		// limit lowered under the count mid-image
		stim_table.push_back(cfg_row(14'd9, 28'd1));
		stim_table.push_back(byte_row(8'h42, 1'b0, PIN_ONE, one_seg(8'h42, 9'd1, 1'b1, 1'b0)));
		// narrow width and zero limit
		stim_table.push_back(cfg_row(14'd4, 28'd0));
		stim_table.push_back(byte_row(8'hAA, 1'b1, PIN_ONE, one_seg(8'hAA, 9'd1, 1'b1, 1'b0)));
		// widest line, run clipped by the limit
		stim_table.push_back(cfg_row(LINE_WIDTH_MAX, 28'd5));
		stim_table.push_back(byte_row(rrle_pkg::ESC_BYTE, 1'b1, PIN_NONE));
		stim_table.push_back(byte_row(8'd9, 1'b0, PIN_NONE));
		stim_table.push_back(byte_row(8'h3C, 1'b0, PIN_ONE, one_seg(8'h3C, 9'd5, 1'b1, 1'b0)));
		// limit reached on a pad byte
		stim_table.push_back(cfg_row(14'd9, 28'd10));
		stim_table.push_back(byte_row(rrle_pkg::ESC_BYTE, 1'b1, PIN_NONE));
		stim_table.push_back(byte_row(8'd8, 1'b0, PIN_NONE));
		stim_table.push_back(byte_row(8'h11, 1'b0, PIN_ONE, one_seg(8'h11, 9'd9, 1'b0, 1'b0)));
		stim_table.push_back(byte_row(8'h22, 1'b0, PIN_ONE, one_seg(8'h22, 9'd0, 1'b1, 1'b0)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) begin
				wait_idle();
				set_config(stim_table[i].lw, stim_table[i].tl);
			end else begin
				send_byte(stim_table[i].data, stim_table[i].start, stim_table[i].pin,
					stim_table[i].seg);
			end
		end

		random_target = sent_items + RANDOM_ITEMS;
		while (sent_items < random_target) random_phase();
		wait_idle();

		if (err_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
